FILE: design/adc_pkg.sv
package adc_pkg;

	localparam int WindowBytes = 65536;
	localparam int AddrW = $clog2(WindowBytes);
	localparam int CntW = 25;
	localparam logic [CntW-1:0] LimitReset = CntW'(65536);

	localparam logic [1:0] StOk = 2'd0;
	localparam logic [1:0] StDist = 2'd1;
	localparam logic [1:0] StOvf = 2'd2;
	localparam logic [1:0] StTrunc = 2'd3;

	typedef enum logic [1:0] {
		PH_CMD  = 2'd0,
		PH_LIT  = 2'd1,
		PH_HIGH = 2'd2,
		PH_LOW  = 2'd3
	} phase_t;

	// controller -> datapath
	typedef struct packed {
		logic       clear;     // reset block state
		logic       load_cmd;  // latch command byte fields
		logic       load_high; // latch distance high byte
		logic       lit_write; // write literal into history
		logic       copy_start;// latch source address, start copy
		logic       copy_read; // read one copy byte from history
		logic       copy_step; // write one copy byte
		logic       emit;      // load output register
		logic [2:0] emit_cnt;
		logic       emit_end;
		logic [1:0] emit_status;
		logic       emit_lit;  // emit the literal byte
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [CntW-1:0] produced;
		logic [6:0]      match_len;
		logic [7:0]      dist_high;
		logic [7:0]      lit_left;
		logic [1:0]      grp;
	} dp_stat_t;

endpackage

FILE: design/adc_datapath.sv
module adc_datapath
	import adc_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  dp_cmd_t         cmd,
	input  logic [7:0]      in_byte,
	output dp_stat_t        stat,
	output logic [31:0]     obytes,
	output logic [2:0]      ocnt,
	output logic            oend,
	output logic [1:0]      ostatus
);

	logic [7:0]      hist_q [WindowBytes];
	logic [CntW-1:0] produced_q;
	logic [6:0]      mlen_q;
	logic [7:0]      dhigh_q;
	logic [7:0]      lit_q;
	logic [AddrW-1:0] src_q;
	logic [7:0]      rd_q;
	logic [31:0]     buf_q;
	logic [1:0]      pos_q;
	logic [AddrW-1:0] wr_addr;
	logic [16:0]     copy_dist;
	logic [31:0]     merged;

	assign copy_dist = {1'b0, dhigh_q, in_byte} + 17'd1;
	assign wr_addr = produced_q[AddrW-1:0];

	// current group with the byte being written placed at its slot
	always_comb begin
		merged = buf_q;
		merged[{pos_q, 3'b000} +: 8] = rd_q;
	end

	// copy reads a byte into rd_q on copy_read and writes it on copy_step, so distance 1
	// reads back the byte that was just written
	always_ff @(posedge clk) begin
		if (cmd.copy_read)
			rd_q <= hist_q[src_q];
		if (cmd.lit_write)
			hist_q[wr_addr] <= in_byte;
		else if (cmd.copy_step)
			hist_q[wr_addr] <= rd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			produced_q <= '0;
			mlen_q <= '0;
			dhigh_q <= '0;
			lit_q <= '0;
			pos_q <= '0;
			src_q <= '0;
			buf_q <= '0;
			ocnt <= '0;
			oend <= 1'b0;
			ostatus <= StOk;
			obytes <= '0;
		end else begin
			if (cmd.clear) begin
				produced_q <= '0;
				mlen_q <= '0;
				dhigh_q <= '0;
				lit_q <= '0;
			end else if (cmd.load_cmd) begin
				if (in_byte[7]) lit_q <= {1'b0, in_byte[6:0]} + 8'd1;
				else if (in_byte[6]) mlen_q <= {1'b0, in_byte[5:0]} + 7'd4;
				else begin
					mlen_q <= {3'b0, in_byte[5:2]} + 7'd3;
					dhigh_q <= {6'b0, in_byte[1:0]};
				end
			end else if (cmd.load_high) begin
				dhigh_q <= in_byte;
			end else if (cmd.lit_write) begin
				produced_q <= produced_q + CntW'(1);
				lit_q <= lit_q - 8'd1;
			end else if (cmd.copy_start) begin
				dhigh_q <= '0;
			end else if (cmd.copy_step) begin
				produced_q <= produced_q + CntW'(1);
				mlen_q <= mlen_q - 7'd1;
			end

			if (cmd.copy_start) begin
				src_q <= wr_addr - copy_dist[AddrW-1:0];
				pos_q <= '0;
				buf_q <= '0;
			end else if (cmd.copy_read) begin
				src_q <= src_q + AddrW'(1);
			end else if (cmd.copy_step) begin
				if (cmd.emit) begin
					pos_q <= '0;
					buf_q <= '0;
				end else begin
					buf_q <= merged;
					pos_q <= pos_q + 2'd1;
				end
			end

			if (cmd.emit) begin
				ocnt <= cmd.emit_cnt;
				oend <= cmd.emit_end;
				ostatus <= cmd.emit_status;
				if (cmd.emit_lit) obytes <= {24'd0, in_byte};
				else if (cmd.copy_step) obytes <= merged;
				else obytes <= '0;
			end
		end
	end

	assign stat.produced = produced_q;
	assign stat.match_len = mlen_q;
	assign stat.dist_high = dhigh_q;
	assign stat.lit_left = lit_q;
	assign stat.grp = pos_q;

endmodule

FILE: design/adc_ctrl.sv
module adc_ctrl
	import adc_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      in_byte,
	input  logic            in_last,
	input  logic [CntW-1:0] limit,
	input  dp_stat_t        stat,
	output dp_cmd_t         cmd,
	output logic            out_valid,
	input  logic            out_ready
);

	typedef enum logic [1:0] {S_IN, S_RD, S_COPY} state_t;

	state_t      state_q;
	phase_t      phase_q;
	logic        err_q;
	logic        last_q;
	logic        ov_q;
	logic        acc;
	logic        out_free;
	logic        set_err;
	logic        emit_now;
	logic [16:0] copy_dist;
	logic [CntW:0] need_lit;
	logic [CntW:0] need_copy;

	assign out_free = !ov_q || out_ready;
	assign in_ready = (state_q == S_IN) && out_free;
	assign acc = in_valid && in_ready;
	assign out_valid = ov_q;
	assign copy_dist = {1'b0, stat.dist_high, in_byte} + 17'd1;
	assign need_lit = {1'b0, stat.produced} + (CntW+1)'(in_byte[6:0]) + (CntW+1)'(1);
	assign need_copy = {1'b0, stat.produced} + (CntW+1)'(stat.match_len);
	// a group goes out after its fourth byte or the last byte of the match
	assign emit_now = (stat.match_len == 7'd1) || (stat.grp == 2'd3);

	always_comb begin
		cmd = '0;
		set_err = 1'b0;
		unique case (state_q)
			S_IN: if (acc) begin
				if (err_q) begin
					cmd.clear = in_last;
				end else begin
					unique case (phase_q)
						PH_CMD: begin
							if (stat.produced >= limit) begin
								// output full: clean end, rest of the block is dropped
								cmd.emit = 1'b1; cmd.emit_end = 1'b1; cmd.emit_status = StOk;
							end else if (in_last) begin
								cmd.emit = 1'b1; cmd.emit_end = 1'b1; cmd.emit_status = StTrunc;
							end else if (in_byte[7] && need_lit > {1'b0, limit}) begin
								cmd.emit = 1'b1; cmd.emit_end = 1'b1; cmd.emit_status = StOvf;
							end else cmd.load_cmd = 1'b1;
						end
						PH_LIT: begin
							if (in_last && stat.lit_left > 8'd1) begin
								cmd.emit = 1'b1; cmd.emit_end = 1'b1; cmd.emit_status = StTrunc;
							end else begin
								cmd.lit_write = 1'b1; cmd.emit = 1'b1; cmd.emit_lit = 1'b1;
								cmd.emit_cnt = 3'd1; cmd.emit_end = in_last;
							end
						end
						PH_HIGH: begin
							if (in_last) begin
								cmd.emit = 1'b1; cmd.emit_end = 1'b1; cmd.emit_status = StTrunc;
							end else cmd.load_high = 1'b1;
						end
						PH_LOW: begin
							if (({8'd0, copy_dist} > stat.produced) ||
									(copy_dist > 17'(WindowBytes))) begin
								cmd.emit = 1'b1; cmd.emit_end = 1'b1; cmd.emit_status = StDist;
							end else if (need_copy > {1'b0, limit}) begin
								cmd.emit = 1'b1; cmd.emit_end = 1'b1; cmd.emit_status = StOvf;
							end else cmd.copy_start = 1'b1;
						end
						default: ;
					endcase
					// an end before the last byte means the rest of the block is dropped
					cmd.clear = in_last && cmd.emit_end;
					set_err = !in_last && cmd.emit_end;
				end
			end
			S_RD: cmd.copy_read = 1'b1;
			S_COPY: if (out_free || !emit_now) begin
				cmd.copy_step = 1'b1;
				cmd.emit = emit_now;
				cmd.emit_cnt = {1'b0, stat.grp} + 3'd1;
				cmd.emit_end = (stat.match_len == 7'd1) && last_q;
				cmd.clear = cmd.emit_end;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IN;
			phase_q <= PH_CMD;
			err_q <= 1'b0;
			last_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (cmd.emit) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;

			if (cmd.clear) begin
				phase_q <= PH_CMD;
				err_q <= 1'b0;
			end else if (set_err) begin
				err_q <= 1'b1;
			end else if (cmd.load_cmd) begin
				phase_q <= in_byte[7] ? PH_LIT : (in_byte[6] ? PH_HIGH : PH_LOW);
			end else if (cmd.lit_write && stat.lit_left == 8'd1) begin
				phase_q <= PH_CMD;
			end else if (cmd.load_high) begin
				phase_q <= PH_LOW;
			end else if (cmd.copy_step && stat.match_len == 7'd1) begin
				phase_q <= PH_CMD;
			end

			unique case (state_q)
				S_IN: if (cmd.copy_start) begin
					state_q <= S_RD;
					last_q <= in_last;
				end
				S_RD: state_q <= S_COPY;
				S_COPY: if (cmd.copy_step) begin
					state_q <= (stat.match_len == 7'd1) ? S_IN : S_RD;
				end
				default: state_q <= S_IN;
			endcase
		end
	end

endmodule

FILE: design/adc_decompressor.sv
// Command, distance and literal bytes are accepted while m_tready keeps up with the output.
// A match of length L copies its bytes one at a time (history read, then write), so the
// next item is accepted only once all L bytes are written; output stalls delay it further.
// A literal or error result is registered and valid in the cycle after its item is accepted.
// arst_n clears all control state and sets output_limit to 65536; history is not cleared.
module adc_decompressor
	import adc_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [CntW-1:0] cfg_wdata,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [7:0]      s_tdata,  // comp_byte
	input  logic            s_tlast,  // last_byte
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [39:0]     m_tdata,  // out_byte0..3, byte_count, zero pad
	output logic [1:0]      m_tuser,  // status
	output logic            m_tlast   // block_end
);

	logic [CntW-1:0] limit_q;
	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic [31:0] obytes;
	logic [2:0]  ocnt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) limit_q <= LimitReset;
		else if (cfg_we) limit_q <= cfg_wdata;
	end

	adc_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(s_tvalid), .in_ready(s_tready),
		.in_byte(s_tdata), .in_last(s_tlast),
		.limit(limit_q), .stat, .cmd,
		.out_valid(m_tvalid), .out_ready(m_tready)
	);

	adc_datapath u_dp (
		.clk, .arst_n, .cmd, .in_byte(s_tdata), .stat,
		.obytes, .ocnt, .oend(m_tlast), .ostatus(m_tuser)
	);

	assign m_tdata = {5'd0, ocnt, obytes};

endmodule

FILE: design/adc_checker.sv
module adc_checker
	import adc_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[34:32] <= 3'd4) else $error("byte_count range");
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != StOk |-> m_tlast && m_tdata[34:32] == 3'd0)
		else $error("error item carries data");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid) else $error("valid dropped");
	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
		else $error("result changed while waiting");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid || m_tready) else $error("input taken while output blocked");

endmodule

bind adc_decompressor adc_checker u_chk (.*);
